FILE: hw/rtl/svpwm_pkg.sv
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants for the SVPWM compare generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam int ANGLE_BITS   = 16;
   localparam int VOLT_BITS    = 16;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_START = 39797;
   localparam int COS30_Q16    = 56756;

   localparam logic [2:0] CSR_BUS_VOLTAGE     = 3'd0;
   localparam logic [2:0] CSR_DUTY_GAIN       = 3'd1;
   localparam logic [2:0] CSR_TIMER_LOAD      = 3'd2;
   localparam logic [2:0] CSR_COUNTS_PER_VOLT = 3'd3;
   localparam logic [2:0] CSR_VOLTAGE_LIMIT   = 3'd4;

   localparam logic [2:0] SEC_2 = 3'd2;
   localparam logic [2:0] SEC_3 = 3'd3;
   localparam logic [2:0] SEC_4 = 3'd4;
   localparam logic [2:0] SEC_5 = 3'd5;

   // atan(2^-i) in 32-bit turns
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] t;
      case (i)
         0:  t = 32'h20000000;
         1:  t = 32'h12E4051E;
         2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;
         4:  t = 32'h028B0D43;
         5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;
         7:  t = 32'h00517C55;
         8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;
         10: t = 32'h000A2F98;
         11: t = 32'h000517CC;
         12: t = 32'h00028BE6;
         13: t = 32'h000145F3;
         14: t = 32'h0000A2FA;
         default: t = 32'h0000517D;
      endcase
      return t;
   endfunction

   typedef struct packed {
      logic [VOLT_BITS-1:0]  volt_d;
      logic [VOLT_BITS-1:0]  volt_q;
      logic [ANGLE_BITS-1:0] elec_angle;
   } req_type;

   typedef struct packed {
      logic [2:0]           sector;
      logic [VOLT_BITS+1:0] term_a;
      logic [VOLT_BITS+1:0] term_b;
      logic [VOLT_BITS+1:0] term_c;
      logic [15:0]          compare_a;
      logic [15:0]          compare_b;
      logic [15:0]          compare_c;
   } rsp_type;

endpackage

FILE: hw/rtl/svpwm_cordic.sv
// ----------------------------------------------------------------------------
// svpwm_cordic
// Pipelined CORDIC sine/cosine, one rotation per stage, voltages carried along.
// ----------------------------------------------------------------------------
module svpwm_cordic import svpwm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [VOLT_BITS-1:0] in_d,
   input  logic signed [VOLT_BITS-1:0] in_q,
   input  logic [ANGLE_BITS-1:0]       in_angle,
   output logic                        out_valid,
   output logic signed [VOLT_BITS-1:0] out_d,
   output logic signed [VOLT_BITS-1:0] out_q,
   output logic signed [17:0]          out_cos,
   output logic signed [17:0]          out_sin
);

   localparam int N = CORDIC_STEPS;

   logic                        v_ff [N+1];
   logic signed [VOLT_BITS-1:0] d_ff [N+1];
   logic signed [VOLT_BITS-1:0] q_ff [N+1];
   logic signed [17:0]          x_ff [N+1];
   logic signed [17:0]          y_ff [N+1];
   logic signed [32:0]          z_ff [N+1];

   logic signed [32:0] z0_in;
   logic signed [17:0] x0_in;

   // fold into +-90 degrees
   always_comb begin
      logic signed [32:0] z;
      z = 33'(signed'({in_angle, {(32-ANGLE_BITS){1'b0}}}));
      x0_in = 18'sd39797;
      if (z > 33'sh040000000 || z < -33'sh040000000) begin
         z = (z > 0) ? z - 33'sh080000000 : z + 33'sh080000000;
         x0_in = -18'sd39797;
      end
      z0_in = z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      d_ff[0] <= in_d;
      q_ff[0] <= in_q;
      x_ff[0] <= x0_in;
      y_ff[0] <= '0;
      z_ff[0] <= z0_in;
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
         d_ff[i+1] <= d_ff[i];
         q_ff[i+1] <= q_ff[i];
         if (z_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - signed'({1'b0, atan_turn(i)});
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + signed'({1'b0, atan_turn(i)});
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_d     = d_ff[N];
   assign out_q     = q_ff[N];
   assign out_cos   = x_ff[N];
   assign out_sin   = y_ff[N];

endmodule

FILE: hw/rtl/svpwm_project.sv
// ----------------------------------------------------------------------------
// svpwm_project
// Inverse Park, projections, sector and per-sector sums, registered in stages.
// ----------------------------------------------------------------------------
module svpwm_project import svpwm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [VOLT_BITS-1:0] in_d,
   input  logic signed [VOLT_BITS-1:0] in_q,
   input  logic signed [17:0]          in_cos,
   input  logic signed [17:0]          in_sin,
   input  logic [VOLT_BITS-1:0]        bus_voltage,
   output logic                        out_valid,
   output logic [2:0]                  out_sector,
   output logic signed [VOLT_BITS+5:0] out_sum [3]
);

   localparam int PW = VOLT_BITS + 18;  // product width
   localparam int AW = VOLT_BITS + 2;   // alpha/beta width
   localparam int XW = AW + 18;         // projection scaled by 2^16
   localparam int SW = VOLT_BITS + 6;

   // stage 1: four products
   logic          v1_ff;
   logic signed [PW-1:0] dc_ff, qs_ff, ds_ff, qc_ff;
   // stage 2: alpha, beta
   logic          v2_ff;
   logic signed [AW-1:0] al_ff, be_ff;
   // stage 3: projections
   logic          v3_ff;
   logic signed [XW-1:0] ax_ff, bh_ff;
   logic signed [AW-1:0] be3_ff;
   // stage 4: sector, sums
   logic          v4_ff;
   logic [2:0]    sec_ff;
   logic signed [SW-1:0] sum_ff [3];

   logic signed [PW:0]   al_w, be_w;
   logic signed [XW-1:0] x2, y2;
   logic signed [SW-1:0] px, py, pz, vb;
   logic [2:0]           sec_in;
   logic signed [SW-1:0] sum_in [3];

   assign al_w = (PW+1)'(dc_ff) - (PW+1)'(qs_ff);
   assign be_w = (PW+1)'(ds_ff) + (PW+1)'(qc_ff);

   assign x2 = ax_ff + bh_ff;
   assign y2 = bh_ff - ax_ff;
   assign px = SW'(x2 >>> 16);
   assign py = SW'(y2 >>> 16);
   assign pz = SW'(be3_ff);
   assign vb = SW'(signed'({1'b0, bus_voltage}));
   assign sec_in = {x2 <= 0, y2 <= 0, be3_ff > 0};

   always_comb begin
      case (sec_in)
         SEC_2, SEC_5: begin
            sum_in[0] = vb + px - pz;
            sum_in[1] = vb - px + pz;
            sum_in[2] = vb - px - pz;
         end
         SEC_3, SEC_4: begin
            sum_in[0] = vb - py + pz;
            sum_in[1] = vb + py + pz;
            sum_in[2] = vb + py - pz;
         end
         default: begin
            sum_in[0] = vb + px - py;
            sum_in[1] = vb + px + py;
            sum_in[2] = vb - px - py;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      dc_ff  <= PW'(in_d * in_cos);
      qs_ff  <= PW'(in_q * in_sin);
      ds_ff  <= PW'(in_d * in_sin);
      qc_ff  <= PW'(in_q * in_cos);
      al_ff  <= AW'(al_w >>> 16);
      be_ff  <= AW'(be_w >>> 16);
      ax_ff  <= XW'(al_ff * signed'(18'sd56756));
      bh_ff  <= XW'(be_ff) <<< 15;
      be3_ff <= be_ff;
      sec_ff <= sec_in;
      sum_ff <= sum_in;
   end

   assign out_valid  = v4_ff;
   assign out_sector = sec_ff;
   assign out_sum    = sum_ff;

endmodule

FILE: hw/rtl/svpwm_duty.sv
// ----------------------------------------------------------------------------
// svpwm_duty
// Gain, term saturation and compare value per channel, three stages.
// ----------------------------------------------------------------------------
module svpwm_duty import svpwm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [2:0]                  in_sector,
   input  logic signed [VOLT_BITS+5:0] in_sum [3],
   input  logic [15:0]                 duty_gain,
   input  logic [15:0]                 timer_load,
   input  logic [15:0]                 counts_per_volt,
   output logic                        out_valid,
   output logic [2:0]                  out_sector,
   output logic signed [VOLT_BITS+1:0] out_term [3],
   output logic [15:0]                 out_compare [3]
);

   localparam int SW = VOLT_BITS + 6;
   localparam int GW = SW + 17;
   localparam int TW = VOLT_BITS + 2;
   localparam int CW = TW + 17 + 2;
   localparam logic signed [GW-13:0] TMAX = (GW-12)'((1 <<< (TW-1)) - 1);
   localparam logic signed [GW-13:0] TMIN = -TMAX - 1;

   logic          v1_ff, v2_ff, v3_ff;
   logic [2:0]    s1_ff, s2_ff, s3_ff;
   logic signed [GW-1:0] g_ff [3];
   logic signed [TW-1:0] t2_ff [3];
   logic signed [CW-1:0] p_ff [3];
   logic signed [TW-1:0] t3_ff [3];
   logic [15:0]          cmp3 [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      s1_ff <= in_sector;
      s2_ff <= s1_ff;
      s3_ff <= s2_ff;
   end

   for (genvar k = 0; k < 3; k++) begin : g_ch
      logic signed [GW-13:0] sh;
      logic signed [CW-1:0]  dif;
      assign sh  = (GW-12)'(g_ff[k] >>> 12);
      assign dif = CW'(signed'({1'b0, timer_load, 8'd0})) - p_ff[k];
      always_ff @(posedge clock) begin
         g_ff[k] <= GW'(in_sum[k] * signed'({1'b0, duty_gain}));
         if (sh > TMAX)
            t2_ff[k] <= TW'(TMAX);
         else if (sh < TMIN)
            t2_ff[k] <= TW'(TMIN);
         else
            t2_ff[k] <= TW'(sh);
         p_ff[k]  <= CW'(t2_ff[k] * signed'({1'b0, counts_per_volt}));
         t3_ff[k] <= t2_ff[k];
      end
      always_comb begin
         if (dif < 0)
            cmp3[k] = '0;
         else if ((dif >>> 8) > CW'(65535))
            cmp3[k] = 16'hFFFF;
         else
            cmp3[k] = dif[23:8];
      end
      assign out_term[k]    = t3_ff[k];
      assign out_compare[k] = cmp3[k];
   end

   assign out_valid  = v3_ff;
   assign out_sector = s3_ff;

endmodule

FILE: hw/rtl/svpwm_compare_generator_unit.sv
// ----------------------------------------------------------------------------
// svpwm_compare_generator_unit
// Space-vector PWM compare generator on an inverse Park transform.
// ----------------------------------------------------------------------------
// Takes one request per clock (busy is always low) and returns exactly one
// response per request on rsp_valid, for one cycle; the receiver cannot
// stall it. Pipeline: 1 angle fold + 16 CORDIC rotations + 4 Park/projection
// stages + 3 gain/compare stages. Registers must only be written while no
// request is in flight.
// ----------------------------------------------------------------------------
module svpwm_compare_generator_unit import svpwm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [VOLT_BITS-1:0] bus_voltage_ff;
   logic [15:0]          duty_gain_ff, timer_load_ff, counts_per_volt_ff;
   logic [VOLT_BITS-2:0] voltage_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_voltage_ff     <= VOLT_BITS'(7629);
         duty_gain_ff       <= 16'd6529;
         timer_load_ff      <= 16'd1000;
         counts_per_volt_ff <= 16'd10;
         voltage_limit_ff   <= (VOLT_BITS-1)'(3545);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BUS_VOLTAGE:     bus_voltage_ff     <= VOLT_BITS'(csr_wdata);
            CSR_DUTY_GAIN:       duty_gain_ff       <= csr_wdata;
            CSR_TIMER_LOAD:      timer_load_ff      <= csr_wdata;
            CSR_COUNTS_PER_VOLT: counts_per_volt_ff <= csr_wdata;
            CSR_VOLTAGE_LIMIT:   voltage_limit_ff   <= (VOLT_BITS-1)'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // symmetric clamp
   logic signed [VOLT_BITS-1:0] lim, d_cl, q_cl, d_raw, q_raw;
   assign lim   = signed'({1'b0, voltage_limit_ff});
   assign d_raw = signed'(req_data.volt_d);
   assign q_raw = signed'(req_data.volt_q);
   assign d_cl  = (d_raw > lim) ? lim : ((d_raw < -lim) ? -lim : d_raw);
   assign q_cl  = (q_raw > lim) ? lim : ((q_raw < -lim) ? -lim : q_raw);

   logic                        c_valid;
   logic signed [VOLT_BITS-1:0] c_d, c_q;
   logic signed [17:0]          c_cos, c_sin;

   svpwm_cordic u_cordic (
      .clock, .reset,
      .in_valid (start),
      .in_d     (d_cl),
      .in_q     (q_cl),
      .in_angle (req_data.elec_angle),
      .out_valid(c_valid),
      .out_d    (c_d),
      .out_q    (c_q),
      .out_cos  (c_cos),
      .out_sin  (c_sin)
   );

   logic                        p_valid;
   logic [2:0]                  p_sector;
   logic signed [VOLT_BITS+5:0] p_sum [3];

   svpwm_project u_project (
      .clock, .reset,
      .in_valid   (c_valid),
      .in_d       (c_d),
      .in_q       (c_q),
      .in_cos     (c_cos),
      .in_sin     (c_sin),
      .bus_voltage(bus_voltage_ff),
      .out_valid  (p_valid),
      .out_sector (p_sector),
      .out_sum    (p_sum)
   );

   logic                        o_valid;
   logic [2:0]                  o_sector;
   logic signed [VOLT_BITS+1:0] o_term [3];
   logic [15:0]                 o_cmp [3];

   svpwm_duty u_duty (
      .clock, .reset,
      .in_valid       (p_valid),
      .in_sector      (p_sector),
      .in_sum         (p_sum),
      .duty_gain      (duty_gain_ff),
      .timer_load     (timer_load_ff),
      .counts_per_volt(counts_per_volt_ff),
      .out_valid      (o_valid),
      .out_sector     (o_sector),
      .out_term       (o_term),
      .out_compare    (o_cmp)
   );

   assign rsp_valid          = o_valid;
   assign rsp_data.sector    = o_sector;
   assign rsp_data.term_a    = o_term[0];
   assign rsp_data.term_b    = o_term[1];
   assign rsp_data.term_c    = o_term[2];
   assign rsp_data.compare_a = o_cmp[0];
   assign rsp_data.compare_b = o_cmp[1];
   assign rsp_data.compare_c = o_cmp[2];

endmodule

FILE: hw/rtl/svpwm_checker.sv
// ----------------------------------------------------------------------------
// svpwm_checker
// Port-level checks on the compare generator.
// ----------------------------------------------------------------------------
module svpwm_checker import svpwm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.sector != 3'd0 && rsp_data.sector != 3'd7))
      else $error("bad sector");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##24 rsp_valid)
      else $error("response missing");

endmodule

bind svpwm_compare_generator_unit svpwm_checker u_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_data
);
